// File: src/pvi_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pvi_pkg: shared types and constants of the position Verlet integrator
// Holds the field widths, the register indexes and the item types that pass
// from the front part to the back part.
// ----------------------------------------------------------------------------
package pvi_pkg;

   localparam int MaxParticles = 1024;
   localparam int IdxW = $clog2(MaxParticles);
   localparam int PartW = 10;
   localparam int PosW = 32;
   localparam int SumW = 63;
   localparam int QueueDepth = 2;

   localparam logic [1:0] CSR_BOX = 2'd0;
   localparam logic [1:0] CSR_DT_SQ = 2'd1;
   localparam logic [1:0] CSR_INV = 2'd2;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_STEP = 1'b1;

   typedef struct packed {
      logic                  op;
      logic                  ok;
      logic [IdxW-1:0]       idx;
      logic                  eos;
      logic signed [PosW-1:0] a_x;
      logic signed [PosW-1:0] a_y;
      logic signed [PosW-1:0] a_z;
      logic signed [PosW-1:0] b_x;
      logic signed [PosW-1:0] b_y;
      logic signed [PosW-1:0] b_z;
   } item_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_WAIT,
      ST_MUL,
      ST_SUM,
      ST_WRAP,
      ST_IMG,
      ST_VMUL,
      ST_VSAT,
      ST_SQ,
      ST_VEL,
      ST_SQR,
      ST_ACC,
      ST_TOT,
      ST_OUT
   } back_state_type;

endpackage
`default_nettype wire

// File: src/position_verlet_integrator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// position_verlet_integrator: periodic-box position Verlet step
// Keeps current and previous positions of up to 1024 particles and sums the
// squared velocity over a sweep.
// ----------------------------------------------------------------------------
// A load word writes both positions of one particle; a step word brings the
// force on a particle, forms 2*cur - prev + dt_sq*force, wraps it into the
// box, takes the minimum-image velocity and adds its square to a saturating
// sum that is reported and cleared on the word marked end of sweep. Every
// word gives exactly one response word. The front part queues up to two
// words; the back part handles one word at a time: a load skips to the output
// state once the memory read is done, and a step runs the per-axis sequence
// of a shared multiply, sum, wrap, saturate, minimum image, magnitude,
// velocity scale, velocity saturate, square and accumulate (three axes in
// turn), then a state that folds the axes into the sum. A response that is
// not taken holds the back part in the output state of the next word until
// it is. Positions sit in two memories with one read and one write port each;
// entries are undefined until loaded. Configuration writes are taken at once
// and must be made while the block is idle.
module position_verlet_integrator (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        csr_we,
   input  wire  [1:0]                 csr_index,
   input  wire  [31:0]                csr_wdata,
   input  wire                        req_valid,
   output logic                       req_ready,
   input  wire                        req_op,
   input  wire  [9:0]                 req_particle,
   input  wire  signed [31:0]         req_a_x,
   input  wire  signed [31:0]         req_a_y,
   input  wire  signed [31:0]         req_a_z,
   input  wire  signed [31:0]         req_b_x,
   input  wire  signed [31:0]         req_b_y,
   input  wire  signed [31:0]         req_b_z,
   input  wire                        req_end_of_sweep,
   output logic                       rsp_valid,
   input  wire                        rsp_ready,
   output logic signed [31:0]         rsp_pos_x,
   output logic signed [31:0]         rsp_pos_y,
   output logic signed [31:0]         rsp_pos_z,
   output logic [62:0]                rsp_speed_sq_sum,
   output logic                       rsp_sweep_done
);
   import pvi_pkg::*;

   // Queue between the classifier and the integration sequencer.
   logic item_valid, item_ready;
   item_type item;

   pvi_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_op, .req_particle,
      .req_a_x, .req_a_y, .req_a_z, .req_b_x, .req_b_y, .req_b_z,
      .req_end_of_sweep, .item_valid, .item_ready, .item
   );

   pvi_back u_back (
      .clock, .reset, .csr_we, .csr_index, .csr_wdata,
      .item_valid, .item_ready, .item,
      .rsp_valid, .rsp_ready, .rsp_pos_x, .rsp_pos_y, .rsp_pos_z,
      .rsp_speed_sq_sum, .rsp_sweep_done
   );
endmodule
`default_nettype wire

// File: src/pvi_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pvi_front: input classifier and item queue
// Takes words from the request channel, checks the particle index and keeps
// them in a short queue for the back part.
// ----------------------------------------------------------------------------
module pvi_front (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           req_valid,
   output logic                          req_ready,
   input  wire                           req_op,
   input  wire  [pvi_pkg::PartW-1:0]     req_particle,
   input  wire  signed [31:0]            req_a_x,
   input  wire  signed [31:0]            req_a_y,
   input  wire  signed [31:0]            req_a_z,
   input  wire  signed [31:0]            req_b_x,
   input  wire  signed [31:0]            req_b_y,
   input  wire  signed [31:0]            req_b_z,
   input  wire                           req_end_of_sweep,
   output logic                          item_valid,
   input  wire                           item_ready,
   output pvi_pkg::item_type             item
);
   import pvi_pkg::*;

   item_type q_ff [QueueDepth];
   logic [$clog2(QueueDepth+1)-1:0] cnt_ff, cnt_in;
   logic push, pop;
   item_type w;

   always_comb begin
      w.op = req_op;
      w.ok = ({{(32-PartW){1'b0}}, req_particle} < 32'(MaxParticles));
      w.idx = req_particle[IdxW-1:0];
      w.eos = req_end_of_sweep;
      w.a_x = req_a_x;
      w.a_y = req_a_y;
      w.a_z = req_a_z;
      w.b_x = req_b_x;
      w.b_y = req_b_y;
      w.b_z = req_b_z;
   end

   assign req_ready = (cnt_ff != QueueDepth[$bits(cnt_ff)-1:0]);
   assign push = req_valid && req_ready;
   assign item_valid = (cnt_ff != '0);
   assign pop = item_valid && item_ready;
   assign item = q_ff[0];

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) cnt_in = cnt_ff + 1'b1;
      else if (pop && !push) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   // Two-entry shift queue; the head always sits in entry 0. A push together
   // with a pop can only happen with one word held, so the new word becomes
   // the head.
   always_ff @(posedge clock) begin
      if (push && (cnt_ff == 2'd0 || pop)) begin
         q_ff[0] <= w;
      end else if (pop) begin
         q_ff[0] <= q_ff[1];
      end
      if (push && !pop && cnt_ff == 2'd1) begin
         q_ff[1] <= w;
      end
   end
endmodule
`default_nettype wire

// File: src/pvi_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pvi_back: integration sequencer
// Reads the position pair of one particle, works out the new position and
// the velocity square sum one step at a time, and writes the result.
// ----------------------------------------------------------------------------
module pvi_back (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         csr_we,
   input  wire  [1:0]                  csr_index,
   input  wire  [31:0]                 csr_wdata,
   input  wire                         item_valid,
   output logic                        item_ready,
   input  pvi_pkg::item_type           item,
   output logic                        rsp_valid,
   input  wire                         rsp_ready,
   output logic signed [31:0]          rsp_pos_x,
   output logic signed [31:0]          rsp_pos_y,
   output logic signed [31:0]          rsp_pos_z,
   output logic [62:0]                 rsp_speed_sq_sum,
   output logic                        rsp_sweep_done
);
   import pvi_pkg::*;

   localparam logic [62:0] SumMax = {63{1'b1}};

   logic [30:0] box_ff;
   logic [31:0] dt_ff;
   logic [30:0] inv_ff;

   logic [3*PosW-1:0] cur_mem [MaxParticles];
   logic [3*PosW-1:0] prev_mem [MaxParticles];
   logic [3*PosW-1:0] cur_rd_ff, prev_rd_ff;

   back_state_type st_ff, st_in;
   item_type it_ff;
   logic [1:0] ax_ff;
   logic signed [PosW-1:0] cur_ff, prev_ff, frc_ff;
   logic signed [63:0] prod_ff;
   logic signed [34:0] s_ff;
   logic signed [PosW-1:0] nw_ff [3];
   logic signed [33:0] d_ff;
   logic [32:0] mag_ff;
   logic [63:0] vp_ff;
   logic [30:0] vel_ff;
   logic [61:0] sq_ff;
   logic [64:0] add_ff;
   logic [62:0] acc_ff;

   logic signed [34:0] box_s, s_w;
   logic signed [35:0] d2;
   logic signed [33:0] d_w;
   logic signed [63:0] prod_w;
   logic [63:0] vp_w;
   logic [64:0] tot;
   logic sel_ok;
   logic out_fire;

   assign box_s = {4'b0, box_ff};
   assign item_ready = (st_ff == ST_IDLE);
   assign out_fire = (st_ff == ST_OUT) && (!rsp_valid || rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         box_ff <= 31'd655360;
         dt_ff <= 32'd107374;
         inv_ff <= 31'd6553600;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_BOX: box_ff <= csr_wdata[30:0];
            CSR_DT_SQ: dt_ff <= csr_wdata;
            CSR_INV: inv_ff <= csr_wdata[30:0];
            default: ;
         endcase
      end
   end

   // Position memories: one read port, one write port each.
   always_ff @(posedge clock) begin
      cur_rd_ff <= cur_mem[it_ff.idx];
      prev_rd_ff <= prev_mem[it_ff.idx];
      if (out_fire && it_ff.ok) begin
         if (it_ff.op == OP_LOAD) begin
            cur_mem[it_ff.idx] <= {it_ff.a_x, it_ff.a_y, it_ff.a_z};
            prev_mem[it_ff.idx] <= {it_ff.b_x, it_ff.b_y, it_ff.b_z};
         end else begin
            cur_mem[it_ff.idx] <= {nw_ff[0], nw_ff[1], nw_ff[2]};
            prev_mem[it_ff.idx] <= cur_rd_ff;
         end
      end
   end

   assign prod_w = 64'($signed(frc_ff)) * $signed({32'b0, dt_ff});
   assign s_w = 35'(2 * 35'(cur_ff)) - 35'(prev_ff) + 35'(prod_ff >>> 32);
   assign d2 = 36'(d_w) <<< 1;
   assign vp_w = 64'(mag_ff[32:16]) * 64'(inv_ff)
                 + ((64'(mag_ff[15:0]) * 64'(inv_ff)) >> 16);
   assign tot = add_ff + 65'(acc_ff);
   assign sel_ok = it_ff.ok && it_ff.op == OP_STEP;

   always_comb begin
      d_w = 34'(nw_ff[ax_ff]) - 34'(prev_ff);
   end

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         ST_IDLE: if (item_valid) st_in = ST_READ;
         ST_READ: st_in = ST_WAIT;
         ST_WAIT: st_in = sel_ok ? ST_MUL : ST_OUT;
         ST_MUL: st_in = ST_SUM;
         ST_SUM: st_in = ST_WRAP;
         ST_WRAP: st_in = ST_IMG;
         ST_IMG: st_in = ST_VMUL;
         ST_VMUL: st_in = ST_VSAT;
         ST_VSAT: st_in = ST_SQ;
         ST_SQ: st_in = ST_VEL;
         ST_VEL: st_in = ST_SQR;
         ST_SQR: st_in = ST_ACC;
         ST_ACC: st_in = (ax_ff == 2'd2) ? ST_TOT : ST_MUL;
         ST_TOT: st_in = ST_OUT;
         ST_OUT: if (out_fire) st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         acc_ff <= '0;
         rsp_valid <= 1'b0;
      end else begin
         st_ff <= st_in;
         if (out_fire) begin
            rsp_valid <= 1'b1;
            if (it_ff.op == OP_STEP && it_ff.eos) acc_ff <= '0;
         end else if (rsp_valid && rsp_ready) begin
            rsp_valid <= 1'b0;
         end
         if (st_ff == ST_TOT) begin
            acc_ff <= (tot > 65'(SumMax)) ? SumMax : tot[62:0];
         end
      end
   end

   // Per-axis datapath registers, one operation per step.
   always_ff @(posedge clock) begin
      unique case (st_ff)
         ST_IDLE: if (item_valid) begin
            it_ff <= item;
         end
         ST_WAIT: begin
            ax_ff <= 2'd0;
            add_ff <= '0;
            cur_ff <= cur_rd_ff[95:64];
            prev_ff <= prev_rd_ff[95:64];
            frc_ff <= it_ff.a_x;
         end
         ST_MUL: prod_ff <= prod_w;
         ST_SUM: s_ff <= s_w;
         ST_WRAP: begin
            if (s_ff >= box_s) s_ff <= s_ff - box_s;
            else if (s_ff < 0) s_ff <= s_ff + box_s;
         end
         ST_IMG: begin
            if (s_ff > 35'sh07FFFFFFF) nw_ff[ax_ff] <= 32'sh7FFFFFFF;
            else if (s_ff < -35'sh080000000) nw_ff[ax_ff] <= 32'sh80000000;
            else nw_ff[ax_ff] <= s_ff[31:0];
         end
         ST_VMUL: begin
            if (d2 > 36'(box_s)) d_ff <= d_w - 34'(box_s);
            else if (d2 < -36'(box_s)) d_ff <= d_w + 34'(box_s);
            else d_ff <= d_w;
         end
         ST_VSAT: mag_ff <= d_ff[33] ? 33'(-d_ff) : 33'(d_ff);
         ST_SQ: begin
            vp_ff <= vp_w;
         end
         ST_ACC: begin
            ax_ff <= ax_ff + 2'd1;
            add_ff <= add_ff + 65'(sq_ff);
            if (ax_ff == 2'd0) begin
               cur_ff <= cur_rd_ff[63:32];
               prev_ff <= prev_rd_ff[63:32];
               frc_ff <= it_ff.a_y;
            end else begin
               cur_ff <= cur_rd_ff[31:0];
               prev_ff <= prev_rd_ff[31:0];
               frc_ff <= it_ff.a_z;
            end
         end
         default: ;
      endcase
      if (out_fire) begin
         if (!it_ff.ok) begin
            rsp_pos_x <= '0;
            rsp_pos_y <= '0;
            rsp_pos_z <= '0;
         end else if (it_ff.op == OP_LOAD) begin
            rsp_pos_x <= it_ff.a_x;
            rsp_pos_y <= it_ff.a_y;
            rsp_pos_z <= it_ff.a_z;
         end else begin
            rsp_pos_x <= nw_ff[0];
            rsp_pos_y <= nw_ff[1];
            rsp_pos_z <= nw_ff[2];
         end
         rsp_speed_sq_sum <= acc_ff;
         rsp_sweep_done <= (it_ff.op == OP_STEP) && it_ff.eos;
      end
   end

   // Velocity saturate and square, registered apart from the scaling multiply.
   // The sequencer gives each of the two stages a state of its own.
   always_ff @(posedge clock) begin
      vel_ff <= (vp_ff > 64'h7FFFFFFF) ? 31'h7FFFFFFF : vp_ff[30:0];
      sq_ff <= 62'(vel_ff) * 62'(vel_ff);
   end
endmodule
`default_nettype wire
